### hw/rtl/igs_pkg.sv
// Shared types, constants and helper functions for the 3x3 Gaussian / Sobel image filter.
`timescale 1ns / 1ps

package igs_pkg;

    // Row store depth and the widths that follow from it.
    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int WCNT_W    = ADDR_W + 1;

    // Fixed field widths.
    localparam int PIX_W     = 24;
    localparam int CH_W      = 8;
    localparam int OUT_X_W   = 11;
    localparam int ROW_W     = 16;
    localparam int CFG_W_W   = 12;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 56;

    // Queue between the front and the back.
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Filter modes; any other code filters as Gaussian.
    localparam logic [MODE_W-1:0] MODE_GAUSS   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SOBEL_V = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SOBEL_H = 2'd2;

    // Luma weights (BT.709 in 16-bit fixed point).
    localparam int LUMA_R = 13933;
    localparam int LUMA_G = 46871;
    localparam int LUMA_B = 4732;

    // Bits of the emit mask carried with each queued pixel.
    localparam int EM_A0 = 0;  // left neighbor column, row above
    localparam int EM_B0 = 1;  // last column, row above
    localparam int EM_A1 = 2;  // left neighbor column, last row
    localparam int EM_B1 = 3;  // last column, last row

    typedef logic [PIX_W-1:0]      pix_t;
    typedef logic [8:0][PIX_W-1:0] win_t;

    // One queued pixel: the window after it shifted in, its position and its emits.
    typedef struct packed {
        win_t              win;
        logic [ADDR_W-1:0] x;
        logic [ROW_W-1:0]  y;
        logic [3:0]        mask;
    } q_entry_t;

    function automatic logic [CH_W-1:0] luma(input pix_t p);
        logic [PIX_W-1:0] acc;
        acc = PIX_W'(LUMA_R * int'(p[23:16]) + LUMA_G * int'(p[15:8]) + LUMA_B * int'(p[7:0]));
        return acc[23:16];
    endfunction

endpackage

### hw/rtl/igs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module igs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/igs_front.sv
// Front end: pixel intake, raster position, row stores, window shift and emit classification.
`timescale 1ns / 1ps

module igs_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [igs_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic [igs_pkg::CFG_W_W-1:0]     image_width,
    input  logic [igs_pkg::ROW_W-1:0]       image_height,
    input  logic [igs_pkg::Q_PTR_W:0]       q_level,
    output logic                            q_push,
    output igs_pkg::q_entry_t               q_data
);

    localparam int AW = igs_pkg::ADDR_W;
    localparam int WW = igs_pkg::WCNT_W;
    localparam int RW = igs_pkg::ROW_W;

    logic [AW-1:0] column_count_reg, column_count_next;
    logic [RW-1:0] row_count_reg, row_count_next;

    logic              p1_valid_reg;
    logic [AW-1:0]     p1_x_reg;
    logic [RW-1:0]     p1_y_reg;
    logic [3:0]        p1_mask_reg;
    igs_pkg::pix_t     p1_pix_reg;

    igs_pkg::win_t     win_reg, win_next;

    logic [WW-1:0]     w_eff;
    logic [RW-1:0]     h_eff;
    logic [AW-1:0]     x_cur;
    logic [RW-1:0]     y_cur;
    logic              last_col, last_row, row_gt0, col_gt0;
    logic [3:0]        mask;
    logic              accept;
    logic [2*igs_pkg::PIX_W-1:0] rs_rdata;

    assign s_tready = ((q_level + (igs_pkg::Q_PTR_W+1)'(p1_valid_reg))
                       < (igs_pkg::Q_PTR_W+1)'(igs_pkg::Q_DEPTH));
    assign accept   = s_tvalid && s_tready;

    // Effective frame size and clamped position.
    always_comb begin
        if (image_width < igs_pkg::CFG_W_W'(2)) begin
            w_eff = WW'(2);
        end else if (32'(image_width) > igs_pkg::MAX_WIDTH) begin
            w_eff = WW'(igs_pkg::MAX_WIDTH);
        end else begin
            w_eff = WW'(image_width);
        end
        h_eff = (image_height < RW'(2)) ? RW'(2) : image_height;

        x_cur = ({1'b0, column_count_reg} >= w_eff) ? AW'(w_eff - WW'(1)) : column_count_reg;
        y_cur = (row_count_reg >= h_eff) ? h_eff - RW'(1) : row_count_reg;

        last_col = ({1'b0, x_cur} == (w_eff - WW'(1)));
        last_row = (y_cur == (h_eff - RW'(1)));
        row_gt0  = (y_cur != '0);
        col_gt0  = (x_cur != '0);

        mask = '0;
        mask[igs_pkg::EM_A0] = row_gt0 && col_gt0;
        mask[igs_pkg::EM_B0] = row_gt0 && last_col;
        mask[igs_pkg::EM_A1] = row_gt0 && last_row && col_gt0;
        mask[igs_pkg::EM_B1] = row_gt0 && last_row && last_col;

        if (last_col) begin
            column_count_next = '0;
            row_count_next    = last_row ? '0 : y_cur + RW'(1);
        end else begin
            column_count_next = x_cur + AW'(1);
            row_count_next    = y_cur;
        end
    end

    // Both row stores share one memory: upper half is row y-2, lower half row y-1.
    igs_ram #(
        .WIDTH (2 * igs_pkg::PIX_W),
        .DEPTH (igs_pkg::MAX_WIDTH)
    ) u_row_store (
        .aclk  (aclk),
        .we    (p1_valid_reg),
        .waddr (p1_x_reg),
        .wdata ({rs_rdata[igs_pkg::PIX_W-1:0], p1_pix_reg}),
        .re    (accept),
        .raddr (x_cur),
        .rdata (rs_rdata)
    );

    always_comb begin
        win_next = win_reg;
        if (p1_valid_reg) begin
            for (int i = 0; i < 6; i++) begin
                win_next[i] = win_reg[i+3];
            end
            win_next[6] = rs_rdata[2*igs_pkg::PIX_W-1:igs_pkg::PIX_W];
            win_next[7] = rs_rdata[igs_pkg::PIX_W-1:0];
            win_next[8] = p1_pix_reg;
        end
    end

    assign q_push      = p1_valid_reg && (p1_mask_reg != '0);
    assign q_data.win  = win_next;
    assign q_data.x    = p1_x_reg;
    assign q_data.y    = p1_y_reg;
    assign q_data.mask = p1_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            p1_valid_reg     <= 1'b0;
            win_reg          <= '0;
        end else begin
            p1_valid_reg <= accept;
            win_reg      <= win_next;
            if (accept) begin
                column_count_reg <= column_count_next;
                row_count_reg    <= row_count_next;
            end
        end
    end

    // Red arrives in the low byte of tdata; the packed pixel keeps red on top.
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_x_reg    <= x_cur;
            p1_y_reg    <= y_cur;
            p1_mask_reg <= mask;
            p1_pix_reg  <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
        end
    end

endmodule

### hw/rtl/igs_fifo.sv
// Small register queue that carries classified pixels from the front to the back.
`timescale 1ns / 1ps

module igs_fifo (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  igs_pkg::q_entry_t          wdata,
    input  logic                       pop,
    output igs_pkg::q_entry_t          rdata,
    output logic                       empty,
    output logic [igs_pkg::Q_PTR_W:0]  level
);

    localparam int PW = igs_pkg::Q_PTR_W;

    igs_pkg::q_entry_t slot_reg [igs_pkg::Q_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]       count_reg;

    assign rdata = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign level = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### hw/rtl/igs_back.sv
// Back end: emit sequencing, mirrored 3x3 gather, Gaussian and Sobel arithmetic, output register.
`timescale 1ns / 1ps

module igs_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [igs_pkg::MODE_W-1:0]     mode,
    input  igs_pkg::q_entry_t              q_head,
    input  logic                           q_empty,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [igs_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);

    localparam int AW = igs_pkg::ADDR_W;
    localparam int RW = igs_pkg::ROW_W;
    localparam int CW = igs_pkg::CH_W;

    logic advance;

    // Emit selection.
    logic [3:0] done_reg;
    logic [3:0] pending, sel, above;
    logic       sel_last, is_b, pass1;
    logic [AW-1:0] cx;
    logic [RW-1:0] cy;
    logic [1:0] cols [3];
    logic [1:0] rows [3];
    igs_pkg::win_t gather;

    // Stage 1: gathered window.
    logic              b1_valid_reg;
    igs_pkg::win_t     b1_p_reg;
    logic [AW-1:0]     b1_x_reg;
    logic [RW-1:0]     b1_y_reg;
    logic              b1_last_reg, b1_fend_reg;

    // Stage 2: luma and Gaussian sums.
    logic              b2_valid_reg;
    logic [8:0][CW-1:0] b2_l_reg, luma_next;
    logic [2:0][CW-1:0] b2_g_reg, gauss_next;
    logic [AW-1:0]     b2_x_reg;
    logic [RW-1:0]     b2_y_reg;
    logic              b2_last_reg, b2_fend_reg;

    // Output register.
    logic              out_valid_reg;
    logic [CW-1:0]     out_r_reg, out_g_reg, out_b_reg;
    logic [igs_pkg::OUT_X_W-1:0] out_x_reg;
    logic [RW-1:0]     out_y_reg;
    logic              out_last_reg, out_fend_reg;

    logic signed [11:0] sob;
    logic [11:0]        sob_abs;
    logic [CW-1:0]      sob_sat;
    logic [CW-1:0]      r_next, g_next, b_next;

    assign advance = !out_valid_reg || m_tready;

    always_comb begin
        logic [3:0] idx;
        pending  = q_head.mask & ~done_reg;
        sel      = pending & (~pending + 4'd1);
        above    = pending & ~sel;
        sel_last = (above == '0);
        is_b     = sel[igs_pkg::EM_B0] || sel[igs_pkg::EM_B1];
        pass1    = sel[igs_pkg::EM_A1] || sel[igs_pkg::EM_B1];

        cx = is_b ? q_head.x : q_head.x - AW'(1);
        cy = pass1 ? q_head.y : q_head.y - RW'(1);

        if (is_b) begin
            cols[0] = 2'd1; cols[1] = 2'd2; cols[2] = 2'd1;
        end else begin
            cols[0] = (cx == '0) ? 2'd2 : 2'd0; cols[1] = 2'd1; cols[2] = 2'd2;
        end
        if (pass1) begin
            rows[0] = 2'd1; rows[1] = 2'd2; rows[2] = 2'd1;
        end else begin
            rows[0] = (cy == '0) ? 2'd2 : 2'd0; rows[1] = 2'd1; rows[2] = 2'd2;
        end

        for (int dy = 0; dy < 3; dy++) begin
            for (int dx = 0; dx < 3; dx++) begin
                idx = 4'(cols[dx]) * 4'd3 + 4'(rows[dy]);
                gather[dy*3+dx] = q_head.win[idx];
            end
        end
    end

    assign q_pop = advance && !q_empty && sel_last;

    // Luma per tap and weighted Gaussian sum per channel.
    always_comb begin
        logic [9:0] acc;
        logic [CW-1:0] v;
        for (int i = 0; i < 9; i++) begin
            luma_next[i] = igs_pkg::luma(b1_p_reg[i]);
        end
        for (int c = 0; c < 3; c++) begin
            acc = '0;
            for (int i = 0; i < 9; i++) begin
                v = b1_p_reg[i][c*CW +: CW];
                if (i == 4) begin
                    acc = acc + 10'(v >> 2);
                end else if (i == 1 || i == 3 || i == 5 || i == 7) begin
                    acc = acc + 10'(v >> 3);
                end else begin
                    acc = acc + 10'(v >> 4);
                end
            end
            gauss_next[c] = acc[CW-1:0];
        end
    end

    // Sobel response, magnitude and saturation; channel 0 of the packed pixel is blue.
    always_comb begin
        if (mode == igs_pkg::MODE_SOBEL_V) begin
            sob = (12'(b2_l_reg[6]) + (12'(b2_l_reg[7]) << 1) + 12'(b2_l_reg[8]))
                - (12'(b2_l_reg[0]) + (12'(b2_l_reg[1]) << 1) + 12'(b2_l_reg[2]));
        end else begin
            sob = (12'(b2_l_reg[2]) + (12'(b2_l_reg[5]) << 1) + 12'(b2_l_reg[8]))
                - (12'(b2_l_reg[0]) + (12'(b2_l_reg[3]) << 1) + 12'(b2_l_reg[6]));
        end
        sob_abs = sob[11] ? 12'(-sob) : 12'(sob);
        sob_sat = (sob_abs > 12'd255) ? 8'd255 : sob_abs[CW-1:0];

        if (mode == igs_pkg::MODE_SOBEL_V || mode == igs_pkg::MODE_SOBEL_H) begin
            r_next = sob_sat;
            g_next = sob_sat;
            b_next = sob_sat;
        end else begin
            r_next = b2_g_reg[2];
            g_next = b2_g_reg[1];
            b_next = b2_g_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg      <= '0;
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            b1_valid_reg  <= !q_empty;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
            if (!q_empty) begin
                done_reg <= sel_last ? 4'd0 : (done_reg | sel);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            b1_p_reg    <= gather;
            b1_x_reg    <= cx;
            b1_y_reg    <= cy;
            b1_last_reg <= sel_last;
            b1_fend_reg <= sel[igs_pkg::EM_B1];

            b2_l_reg    <= luma_next;
            b2_g_reg    <= gauss_next;
            b2_x_reg    <= b1_x_reg;
            b2_y_reg    <= b1_y_reg;
            b2_last_reg <= b1_last_reg;
            b2_fend_reg <= b1_fend_reg;

            out_r_reg    <= r_next;
            out_g_reg    <= g_next;
            out_b_reg    <= b_next;
            out_x_reg    <= igs_pkg::OUT_X_W'(b2_x_reg);
            out_y_reg    <= b2_y_reg;
            out_last_reg <= b2_last_reg;
            out_fend_reg <= b2_fend_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_b_reg, out_g_reg, out_r_reg, out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_fend_reg;

endmodule

### hw/rtl/image_3x3_gauss_sobel_filter_top.sv
// Top level of the 3x3 Gaussian / Sobel filter: configuration registers and the front/queue/back.
// Path: the front registers each accepted pixel for the row store read, window shift and queue
//   write, and the back pipeline adds three register stages (b1, b2 and the output register).
// Throughput: one pixel per cycle while the four-entry queue has room; a pixel on the last row
//   causes two results (four at its last column), and the single filter datapath in the back end
//   takes one result at a time, so intake is held back there once the queue fills up.
// Reset (aresetn, synchronous, active low): position, window and pipeline valid flags clear, the
//   mode returns to Gaussian, width to 2048 and height to 480; row store contents are not cleared.
`timescale 1ns / 1ps

module image_3x3_gauss_sobel_filter_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Pixel input channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [igs_pkg::S_DATA_W-1:0]      s_tdata,   // in_red, in_green, in_blue
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [igs_pkg::M_DATA_W-1:0]      m_tdata,   // out_x, out_y, out_red, out_green,
                                                         // out_blue, zero fill
    output logic                              m_tlast,   // run_last
    output logic                              m_tuser,   // frame_end
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [igs_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [igs_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

    // Configuration registers. Users write only while no transaction is in flight; not enforced.
    logic [igs_pkg::MODE_W-1:0]  mode_reg;
    logic [igs_pkg::CFG_W_W-1:0] image_width_reg;
    logic [igs_pkg::ROW_W-1:0]   image_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= igs_pkg::MODE_GAUSS;
            image_width_reg  <= igs_pkg::CFG_W_W'(2048);
            image_height_reg <= igs_pkg::ROW_W'(480);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                igs_pkg::CFG_MODE:   mode_reg         <= cfg_wdata[igs_pkg::MODE_W-1:0];
                igs_pkg::CFG_WIDTH:  image_width_reg  <= cfg_wdata[igs_pkg::CFG_W_W-1:0];
                igs_pkg::CFG_HEIGHT: image_height_reg <= cfg_wdata[igs_pkg::ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front end tracks the raster position, keeps the two previous rows and the
    // 3x3 window, and tags every pixel with the results it causes. Pixels with at
    // least one result enter the queue together with a snapshot of the window.
    igs_pkg::q_entry_t          q_wdata, q_rdata;
    logic                       q_push, q_pop, q_empty;
    logic [igs_pkg::Q_PTR_W:0]  q_level;

    igs_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .q_level      (q_level),
        .q_push       (q_push),
        .q_data       (q_wdata)
    );

    igs_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty),
        .level   (q_level)
    );

    // The back end walks the results of each queued pixel in order, applies the mirrored
    // border, runs the selected filter and holds the result in the output register.
    igs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mode     (mode_reg),
        .q_head   (q_rdata),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### sim/tb_image_3x3_gauss_sobel_filter_top.sv
// Self-checking testbench for the 3x3 Gaussian / Sobel image filter top level.
`timescale 1ns / 1ps

module tb_image_3x3_gauss_sobel_filter_top;

    import igs_pkg::*;

    // The package names three modes; the fourth code must filter as Gaussian.
    localparam logic [MODE_W-1:0] MODE_SPARE = MODE_SOBEL_H + 2'd1;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 12;

    // One filtered pixel as the result channel carries it.
    typedef struct packed {
        logic [OUT_X_W-1:0] x;
        logic [ROW_W-1:0]   y;
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
        logic               run_last;
        logic               frame_end;
    } filtered_pixel_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;

    image_3x3_gauss_sobel_filter_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns clock period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Filter state as the testbench predicts it.
    logic [PIX_W-1:0]   older_row [MAX_WIDTH];
    logic [PIX_W-1:0]   upper_row [MAX_WIDTH];
    logic [PIX_W-1:0]   window [9];
    int                 next_col;
    int                 next_row;
    logic [MODE_W-1:0]  cur_mode;
    int                 cur_width;
    int                 cur_height;

    filtered_pixel_t    pending_pixels [$];
    int                 mismatches = 0;
    int                 pixels_sent = 0;
    int                 results_seen = 0;
    int                 frames_seen = 0;
    int                 cycles = 0;
    int                 sender_idle_pct = 0;
    int                 receiver_stall_pct = 0;

    function automatic int luma_of(input logic [PIX_W-1:0] p);
        return (LUMA_R * int'(p[23:16]) + LUMA_G * int'(p[15:8]) + LUMA_B * int'(p[7:0])) >> 16;
    endfunction

    // Filters the current window; cols and rows select window columns and rows,
    // which is how the mirrored border is expressed.
    function automatic filtered_pixel_t filter_window(input int cols[3], input int rows[3],
                                                      input int cx, input int cy);
        filtered_pixel_t  res;
        logic [PIX_W-1:0] p [3][3];
        int               l [3][3];
        int               s;
        int               sum;
        int               wt;
        int               v;
        for (int dy = 0; dy < 3; dy++) begin
            for (int dx = 0; dx < 3; dx++) begin
                p[dy][dx] = window[cols[dx] * 3 + rows[dy]];
                l[dy][dx] = luma_of(p[dy][dx]);
            end
        end
        res = '0;
        res.x = cx[OUT_X_W-1:0];
        res.y = cy[ROW_W-1:0];
        if (cur_mode == MODE_SOBEL_V || cur_mode == MODE_SOBEL_H) begin
            if (cur_mode == MODE_SOBEL_V)
                s = (l[2][0] + 2 * l[2][1] + l[2][2]) - (l[0][0] + 2 * l[0][1] + l[0][2]);
            else
                s = (l[0][2] + 2 * l[1][2] + l[2][2]) - (l[0][0] + 2 * l[1][0] + l[2][0]);
            if (s < 0) s = -s;
            if (s > 255) s = 255;
            res.red = s[7:0];
            res.green = s[7:0];
            res.blue = s[7:0];
        end else begin
            for (int c = 0; c < 3; c++) begin
                sum = 0;
                for (int dy = 0; dy < 3; dy++) begin
                    for (int dx = 0; dx < 3; dx++) begin
                        v = int'((p[dy][dx] >> (16 - 8 * c)) & 24'hFF);
                        wt = int'(dy == 1) + int'(dx == 1);
                        sum += (wt == 2) ? (v >> 2) : (wt == 1) ? (v >> 3) : (v >> 4);
                    end
                end
                if (c == 0) res.red = sum[7:0];
                else if (c == 1) res.green = sum[7:0];
                else res.blue = sum[7:0];
            end
        end
        return res;
    endfunction

    // Advances the predicted filter by one accepted pixel and queues the
    // results it causes: the row above while a row arrives, and on the last
    // row that row's own pixels too.
    task automatic predict_pixel(input logic [PIX_W-1:0] pix);
        filtered_pixel_t res [4];
        int              w;
        int              h;
        int              x;
        int              y;
        int              n;
        int              cy;
        bit              frame_done;
        int              rows [3];
        int              cols [3];
        w = cur_width;
        h = cur_height;
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < 2) h = 2;
        x = (next_col >= w) ? w - 1 : next_col;
        y = (next_row >= h) ? h - 1 : next_row;
        for (int i = 0; i < 6; i++) window[i] = window[i + 3];
        window[6] = older_row[x];
        window[7] = upper_row[x];
        window[8] = pix;
        older_row[x] = upper_row[x];
        upper_row[x] = pix;
        n = 0;
        frame_done = 1'b0;
        if (y >= 1) begin
            for (int pass = 0; pass < 2; pass++) begin
                if (pass == 0) begin
                    cy = y - 1;
                    rows = '{(cy == 0) ? 2 : 0, 1, 2};
                end else begin
                    if (y != h - 1) break;
                    cy = y;
                    rows = '{1, 2, 1};
                end
                if (x >= 1) begin
                    cols = '{(x == 1) ? 2 : 0, 1, 2};
                    res[n] = filter_window(cols, rows, x - 1, cy);
                    n++;
                end
                if (x == w - 1) begin
                    cols = '{1, 2, 1};
                    res[n] = filter_window(cols, rows, x, cy);
                    n++;
                    if (pass == 1) frame_done = 1'b1;
                end
            end
        end
        if (n > 0) begin
            res[n - 1].run_last = 1'b1;
            res[n - 1].frame_end = frame_done;
        end
        for (int i = 0; i < n; i++) pending_pixels.push_back(res[i]);
        x++;
        if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) y = 0;
        end
        next_col = x;
        next_row = y;
    endtask

    // Sends one pixel, with random idle cycles ahead of it as the phase asks.
    task automatic send_pixel(input logic [CH_W-1:0] red, input logic [CH_W-1:0] green,
                              input logic [CH_W-1:0] blue);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {blue, green, red};
        do @(posedge aclk); while (!s_tready);
        predict_pixel({red, green, blue});
        pixels_sent++;
    endtask

    function automatic logic [CH_W-1:0] random_channel();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return CH_W'($urandom);
        endcase
    endfunction

    task automatic send_random_pixel();
        send_pixel(random_channel(), random_channel(), random_channel());
    endtask

    // Sends pixels until the predicted position is back at the frame origin.
    task automatic complete_frame();
        do send_random_pixel(); while (next_col != 0 || next_row != 0);
    endtask

    // Drops the valid at once, then waits until every expected result has
    // arrived and a further drain wait is over, so that a register write
    // finds the block idle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:   cur_mode = value[MODE_W-1:0];
            CFG_WIDTH:  cur_width = int'(value[CFG_W_W-1:0]);
            CFG_HEIGHT: cur_height = int'(value);
            default: ;
        endcase
    endtask

    task automatic configure(input logic [MODE_W-1:0] mode, input int width, input int height);
        write_register(CFG_MODE, CFG_DAT_W'(mode));
        write_register(CFG_WIDTH, CFG_DAT_W'(width));
        write_register(CFG_HEIGHT, CFG_DAT_W'(height));
    endtask

    // The width above range must clamp to the maximum, the zero height to
    // two and the spare mode must filter as Gaussian. Five pixels go into
    // the wide first row, then the width shrinks so the position clamps to
    // the last column and the frame completes.
    task automatic test_register_clamps();
        configure(MODE_SPARE, 4095, 0);
        repeat (5) send_random_pixel();
        wait_idle();
        write_register(CFG_WIDTH, 16'd3);
        complete_frame();
        wait_idle();
    endtask

    // Tiny frames at the field extremes in every mode. A checkerboard of
    // black and white drives the Sobel response to zero.
    task automatic test_extremes();
        configure(MODE_GAUSS, 2, 2);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'h00);
        wait_idle();
        for (int m = 1; m <= 2; m++) begin
            configure(m == 1 ? MODE_SOBEL_V : MODE_SOBEL_H, 3, 3);
            for (int i = 0; i < 9; i++) begin
                if (((i % 3) + (i / 3) + m) % 2 == 0) send_pixel(8'hFF, 8'hFF, 8'hFF);
                else send_pixel(8'h00, 8'h00, 8'h00);
            end
            wait_idle();
        end
        // Width and height below two are treated as two.
        configure(MODE_GAUSS, 1, 1);
        complete_frame();
        wait_idle();
    endtask

    // Registers shrink mid-frame, so the position lies beyond the last
    // row of the frame and must be clamped to it.
    task automatic test_position_clamp();
        configure(MODE_SOBEL_H, 6, 5);
        repeat (15) send_random_pixel();
        wait_idle();
        write_register(CFG_WIDTH, 16'd4);
        write_register(CFG_HEIGHT, 16'd2);
        complete_frame();
        wait_idle();
        configure(MODE_SOBEL_V, 2, 65535);
        repeat (6) send_random_pixel();
        wait_idle();
        write_register(CFG_HEIGHT, 16'd2);
        complete_frame();
        wait_idle();
    endtask

    // Whole frames of random pixels under random small settings.
    task automatic test_random_frames(input int idle_pct, input int stall_pct, input int count);
        int start;
        int width;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        start = pixels_sent;
        while (pixels_sent - start < count) begin
            width = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 2);
            configure(MODE_W'($urandom_range(3)), width, $urandom_range(6, 2));
            complete_frame();
            wait_idle();
        end
    endtask

    // Result checker: compares each accepted transaction with the oldest
    // expectation and sets the ready stall pattern for the next cycle.
    always @(posedge aclk) begin
        filtered_pixel_t got;
        filtered_pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '0;
            got.x = m_tdata[10:0];
            got.y = m_tdata[26:11];
            got.red = m_tdata[34:27];
            got.green = m_tdata[42:35];
            got.blue = m_tdata[50:43];
            got.run_last = m_tlast;
            got.frame_end = m_tuser;
            results_seen++;
            if (m_tuser) frames_seen++;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result x=%0d y=%0d rgb=%h%h%h",
                             got.x, got.y, got.red, got.green, got.blue);
            end else begin
                want = pending_pixels.pop_front();
                if (got !== want || m_tdata[55:51] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected x=%0d y=%0d rgb=%h %h %h last=%b end=%b,",
                                  " got x=%0d y=%0d rgb=%h %h %h last=%b end=%b fill=%h"},
                                 want.x, want.y, want.red, want.green, want.blue,
                                 want.run_last, want.frame_end, got.x, got.y, got.red,
                                 got.green, got.blue, got.run_last, got.frame_end,
                                 m_tdata[55:51]);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, pending_pixels.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            older_row[i] = '0;
            upper_row[i] = '0;
        end
        for (int i = 0; i < 9; i++) window[i] = '0;
        next_col = 0;
        next_row = 0;
        cur_mode = MODE_GAUSS;
        cur_width = 2048;
        cur_height = 480;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_clamps();
        test_extremes();
        test_position_clamp();
        // Random frames with no idling, a slow sender, a slow receiver and both.
        test_random_frames(0, 0, 100);
        test_random_frames(65, 0, 100);
        test_random_frames(0, 65, 100);
        test_random_frames(23, 23, 100);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        wait_idle();

        $display("Covered %0d pixels and %0d filtered results over %0d frames,",
                 pixels_sent, results_seen, frames_seen);
        $display("in all modes, with clamped registers and mid-frame register changes.");
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_pixels.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
